@@ sv/hmpte_pkg.sv @@
// Shared types and constants of the HMP track event parser.
`timescale 1ns / 1ps
`default_nettype none

package hmpte_pkg;

    localparam int unsigned TS_W    = 32;
    localparam int unsigned MLEN_W  = 28;
    localparam int unsigned TDATA_W = 104;

    localparam logic [7:0] STATUS_META    = 8'hFF;
    localparam logic [7:0] STATUS_CH_LO   = 8'h80;
    localparam logic [7:0] STATUS_CH_HI   = 8'hEF;
    localparam logic [3:0] NIBBLE_PROG    = 4'hC;
    localparam logic [3:0] NIBBLE_CHPRESS = 4'hD;
    localparam logic [7:0] META_END_TRACK = 8'h2F;
    localparam logic [2:0] GROUP_MAX      = 3'd5;
    localparam logic [2:0] LEN_BYTES_MAX  = 3'd4;

    typedef enum logic [1:0] {
        KIND_CHAN      = 2'd0,
        KIND_META_HDR  = 2'd1,
        KIND_META_BYTE = 2'd2,
        KIND_ERR       = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       track_last;
    } t_in_item;

    typedef struct packed {
        t_kind              result_kind;
        logic [TS_W-1:0]    timestamp;
        logic [2:0]         msg_type;
        logic [3:0]         channel;
        logic [7:0]         data_first;
        logic [7:0]         data_second;
        logic [1:0]         data_count;
        logic [7:0]         meta_type;
        logic [MLEN_W-1:0]  meta_length;
        logic [7:0]         payload_byte;
        logic               payload_last;
    } t_result;

endpackage

`default_nettype wire

@@ sv/hmp_track_event_parser.sv @@
// Top level of the HMP track event parser: input stage, parser core, result stage.
// A byte waits in the input register; its result is captured in the result register.
// Throughput: one byte per cycle; a stalled result register holds both stages.
// Each byte is decoded in one pass between the input and result registers.
// Reset (synchronous, active low): stages empty, parser waits for a delta byte,
// running time zero and track not halted.
`timescale 1ns / 1ps
`default_nettype none

module hmp_track_event_parser
    import hmpte_pkg::*;
#(
    parameter int unsigned TIME_BITS   = 32,
    parameter int unsigned LENGTH_BITS = 28
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [7:0]         i_s_tdata,   // [7:0] data_byte
    input  wire logic               i_s_tlast,   // track_last
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [TDATA_W-1:0]      o_m_tdata,   // [31:0] timestamp, [34:32] msg_type,
                                                 // [38:35] channel, [46:39] data_first,
                                                 // [54:47] data_second, [56:55] data_count,
                                                 // [64:57] meta_type, [92:65] meta_length,
                                                 // [100:93] payload_byte, [103:101] zero
    output logic [1:0]              o_m_tuser,   // [1:0] result_kind
    output logic                    o_m_tlast    // payload_last
);

    t_in_item s_in_item;
    t_in_item s_core_item;
    logic     s_core_valid;
    logic     s_advance;
    logic     s_emit;
    t_result  s_res;
    t_result  s_out_res;

    assign s_in_item.data_byte  = i_s_tdata;
    assign s_in_item.track_last = i_s_tlast;

    hmpte_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_item    (s_in_item),
        .i_advance (s_advance),
        .o_valid   (s_core_valid),
        .o_item    (s_core_item)
    );

    hmpte_core #(
        .TIME_BITS   (TIME_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_core_valid && s_advance),
        .i_item  (s_core_item),
        .o_emit  (s_emit),
        .o_res   (s_res)
    );

    hmpte_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_emit    (s_emit),
        .i_res     (s_res),
        .o_advance (s_advance),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_res     (s_out_res)
    );

    assign o_m_tdata = {3'b000,
                        s_out_res.payload_byte,
                        s_out_res.meta_length,
                        s_out_res.meta_type,
                        s_out_res.data_count,
                        s_out_res.data_second,
                        s_out_res.data_first,
                        s_out_res.channel,
                        s_out_res.msg_type,
                        s_out_res.timestamp};
    assign o_m_tuser = s_out_res.result_kind;
    assign o_m_tlast = s_out_res.payload_last;

endmodule

`default_nettype wire

@@ sv/hmpte_in_stage.sv @@
// Input register stage: holds one track byte until the parser consumes it.
`timescale 1ns / 1ps
`default_nettype none

module hmpte_in_stage
    import hmpte_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    input  wire logic     i_advance,
    output logic          o_valid,
    output t_in_item      o_item
);

    logic     r_valid;
    t_in_item r_item;

    // Take a new byte when empty or when the held byte moves on this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ sv/hmpte_core.sv @@
// Parser state and single-pass next-state and result logic for one byte.
`timescale 1ns / 1ps
`default_nettype none

module hmpte_core
    import hmpte_pkg::*;
#(
    parameter int unsigned TIME_BITS   = 32,
    parameter int unsigned LENGTH_BITS = 28
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    output logic          o_emit,
    output t_result       o_res
);

    typedef enum logic [2:0] {
        PH_DELTA   = 3'd0,
        PH_STATUS  = 3'd1,
        PH_DATA1   = 3'd2,
        PH_DATA2   = 3'd3,
        PH_MTYPE   = 3'd4,
        PH_MLEN    = 3'd5,
        PH_PAYLOAD = 3'd6
    } t_phase;

    t_phase                 r_phase,      n_phase;
    logic [TIME_BITS-1:0]   r_run_time,   n_run_time;
    logic [TIME_BITS-1:0]   r_delta,      n_delta;
    logic [2:0]             r_groups,     n_groups;
    logic [7:0]             r_status,     n_status;
    logic [7:0]             r_first,      n_first;
    logic [7:0]             r_mtype,      n_mtype;
    logic [LENGTH_BITS-1:0] r_mrem,       n_mrem;
    logic                   r_len_ovf,    n_len_ovf;
    logic [2:0]             r_len_bytes,  n_len_bytes;
    logic                   r_halted,     n_halted;

    logic [7:0]               v_b;
    logic                     v_last;
    logic                     v_emit, v_boundary, v_err, v_halt_after;
    logic [5:0]               v_shamt;
    logic [63:0]              v_grp64;
    logic [TIME_BITS-1:0]     v_grp;
    logic [63:0]              v_rt64;
    logic [LENGTH_BITS+6:0]   v_len_full;
    t_result                  v_res;

    always_comb begin
        v_b          = i_item.data_byte;
        v_last       = i_item.track_last;
        v_emit       = 1'b0;
        v_boundary   = 1'b0;
        v_err        = 1'b0;
        v_halt_after = 1'b0;
        v_res        = '0;

        n_phase     = r_phase;
        n_run_time  = r_run_time;
        n_delta     = r_delta;
        n_groups    = r_groups;
        n_status    = r_status;
        n_first     = r_first;
        n_mtype     = r_mtype;
        n_mrem      = r_mrem;
        n_len_ovf   = r_len_ovf;
        n_len_bytes = r_len_bytes;
        n_halted    = r_halted;

        case (r_groups)
            3'd0:    v_shamt = 6'd0;
            3'd1:    v_shamt = 6'd7;
            3'd2:    v_shamt = 6'd14;
            3'd3:    v_shamt = 6'd21;
            default: v_shamt = 6'd28;
        endcase
        v_grp64    = 64'(v_b[6:0]) << v_shamt;
        v_grp      = TIME_BITS'(v_grp64);
        v_len_full = {r_mrem, v_b[6:0]};

        if (!r_halted) begin
            case (r_phase)
                PH_DELTA: begin
                    if (r_groups < GROUP_MAX) begin
                        n_delta  = r_delta + v_grp;
                        n_groups = r_groups + 3'd1;
                    end
                    if (v_b[7]) begin
                        n_run_time = r_run_time + n_delta;
                        n_delta    = '0;
                        n_groups   = '0;
                        n_phase    = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (v_b == STATUS_META) begin
                        n_phase = PH_MTYPE;
                    end else if (v_b inside {[STATUS_CH_LO:STATUS_CH_HI]}) begin
                        n_status = v_b;
                        n_phase  = PH_DATA1;
                    end else begin
                        v_err = 1'b1;
                    end
                end
                PH_DATA1: begin
                    n_first = v_b;
                    if (r_status[7:4] inside {NIBBLE_PROG, NIBBLE_CHPRESS}) begin
                        v_res.result_kind = KIND_CHAN;
                        v_res.msg_type    = r_status[6:4];
                        v_res.channel     = r_status[3:0];
                        v_res.data_first  = v_b;
                        v_res.data_count  = 2'd1;
                        v_emit            = 1'b1;
                        v_boundary        = 1'b1;
                        n_phase           = PH_DELTA;
                    end else begin
                        n_phase = PH_DATA2;
                    end
                end
                PH_DATA2: begin
                    v_res.result_kind = KIND_CHAN;
                    v_res.msg_type    = r_status[6:4];
                    v_res.channel     = r_status[3:0];
                    v_res.data_first  = r_first;
                    v_res.data_second = v_b;
                    v_res.data_count  = 2'd2;
                    v_emit            = 1'b1;
                    v_boundary        = 1'b1;
                    n_phase           = PH_DELTA;
                end
                PH_MTYPE: begin
                    n_mtype     = v_b;
                    n_mrem      = '0;
                    n_len_ovf   = 1'b0;
                    n_len_bytes = '0;
                    n_phase     = PH_MLEN;
                end
                PH_MLEN: begin
                    // Keep a sticky flag for bits shifted beyond the length width
                    n_mrem      = v_len_full[LENGTH_BITS-1:0];
                    n_len_ovf   = r_len_ovf || (v_len_full[LENGTH_BITS+6:LENGTH_BITS] != '0);
                    n_len_bytes = r_len_bytes + 3'd1;
                    if (v_b[7]) begin
                        if (n_len_bytes >= LEN_BYTES_MAX) begin
                            v_err = 1'b1;
                        end
                    end else if (n_len_ovf) begin
                        v_err = 1'b1;
                    end else begin
                        v_res.result_kind = KIND_META_HDR;
                        v_res.meta_type   = r_mtype;
                        v_res.meta_length = MLEN_W'(n_mrem);
                        v_emit            = 1'b1;
                        if (n_mrem == '0) begin
                            v_boundary   = 1'b1;
                            v_halt_after = (r_mtype == META_END_TRACK);
                            n_phase      = PH_DELTA;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_mrem             = r_mrem - LENGTH_BITS'(1);
                    v_res.result_kind  = KIND_META_BYTE;
                    v_res.meta_type    = r_mtype;
                    v_res.payload_byte = v_b;
                    v_res.payload_last = (n_mrem == '0);
                    v_emit             = 1'b1;
                    if (n_mrem == '0) begin
                        v_boundary   = 1'b1;
                        v_halt_after = (r_mtype == META_END_TRACK);
                        n_phase      = PH_DELTA;
                    end
                end
                default: begin
                    n_phase = PH_DELTA;
                    v_err   = 1'b1;
                end
            endcase

            v_rt64          = 64'(n_run_time);
            v_res.timestamp = v_rt64[TS_W-1:0];

            if (v_err || (v_last && !v_boundary)) begin
                v_res             = '0;
                v_res.result_kind = KIND_ERR;
                v_res.timestamp   = v_rt64[TS_W-1:0];
                v_emit            = 1'b1;
                n_halted          = 1'b1;
            end
            if (!v_last && v_halt_after) begin
                n_halted = 1'b1;
            end
        end else begin
            v_rt64 = 64'(r_run_time);
        end

        // Start the next track after its final byte
        if (v_last) begin
            n_phase     = PH_DELTA;
            n_run_time  = '0;
            n_delta     = '0;
            n_groups    = '0;
            n_mrem      = '0;
            n_len_ovf   = 1'b0;
            n_len_bytes = '0;
            n_halted    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DELTA;
            r_run_time  <= '0;
            r_delta     <= '0;
            r_groups    <= '0;
            r_status    <= '0;
            r_first     <= '0;
            r_mtype     <= '0;
            r_mrem      <= '0;
            r_len_ovf   <= 1'b0;
            r_len_bytes <= '0;
            r_halted    <= 1'b0;
        end else if (i_valid) begin
            r_phase     <= n_phase;
            r_run_time  <= n_run_time;
            r_delta     <= n_delta;
            r_groups    <= n_groups;
            r_status    <= n_status;
            r_first     <= n_first;
            r_mtype     <= n_mtype;
            r_mrem      <= n_mrem;
            r_len_ovf   <= n_len_ovf;
            r_len_bytes <= n_len_bytes;
            r_halted    <= n_halted;
        end
    end

    assign o_emit = i_valid && v_emit;
    assign o_res  = v_res;

    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && r_halted) |-> !o_emit)
        else $error("result produced while track halted");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_item.track_last) |=> (r_phase == PH_DELTA && !r_halted
                                            && r_run_time == '0))
        else $error("track not restarted after final byte");

    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_mrem != '0))
        else $error("payload phase with no bytes remaining");

    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_res.result_kind == KIND_ERR && !i_item.track_last) |=> r_halted)
        else $error("error result did not halt the track");

endmodule

`default_nettype wire

@@ sv/hmpte_out_stage.sv @@
// Result register stage: holds one result transaction until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none

module hmpte_out_stage
    import hmpte_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_emit,
    input  wire t_result i_res,
    output logic         o_advance,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    // Move on when the register is empty or its transaction leaves now
    assign o_advance = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_emit) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

@@ tb/hmp_track_event_checker.sv @@
// Checker of the HMP track event parser: predicts each result and compares it on the output.
`timescale 1ns / 1ps

module hmp_track_event_checker
    import hmpte_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    input  logic [7:0]         i_s_tdata,
    input  logic               i_s_tlast,
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    input  logic [TDATA_W-1:0] i_m_tdata,
    input  logic [1:0]         i_m_tuser,
    input  logic               i_m_tlast,
    output logic [31:0]        o_fail_count,
    output logic [31:0]        o_outstanding
);

    localparam int PRINT_CAP = 40;

    typedef enum logic [3:0] {
        PH_DELTA,
        PH_STATUS,
        PH_DATA1,
        PH_DATA2,
        PH_MTYPE,
        PH_MLEN,
        PH_PAYLOAD
    } t_phase;

    t_phase            phase;
    logic [TS_W-1:0]   run_time;
    logic [TS_W-1:0]   delta_acc;
    logic [2:0]        groups_seen;
    logic [7:0]        status_q;
    logic [7:0]        first_q;
    logic [7:0]        mtype_q;
    logic [MLEN_W-1:0] remaining;
    logic [2:0]        len_bytes;
    logic              halted;

    t_result     expected_results[$];
    int unsigned failures = 0;
    int unsigned backlog  = 0;

    assign o_fail_count  = failures;
    assign o_outstanding = backlog;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        failures++;
        if (failures <= PRINT_CAP)
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    endtask

    function automatic void start_track();
        phase       = PH_DELTA;
        run_time    = '0;
        delta_acc   = '0;
        groups_seen = '0;
        remaining   = '0;
        len_bytes   = '0;
        halted      = 1'b0;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic last,
                              output bit emit, output t_result res);
        bit              done;
        bit              fault;
        bit              close_after;
        logic [TS_W-1:0] grp;
        emit        = 1'b0;
        done        = 1'b0;
        fault       = 1'b0;
        close_after = 1'b0;
        res         = '0;
        if (halted) begin
            if (last)
                start_track();
        end else begin
            case (phase)
                PH_DELTA: begin
                    // drop groups past the fifth
                    if (groups_seen < GROUP_MAX) begin
                        grp         = b[6:0];
                        delta_acc   = delta_acc + (grp << (7 * groups_seen));
                        groups_seen = groups_seen + 3'd1;
                    end
                    if (b[7]) begin
                        run_time    = run_time + delta_acc;
                        delta_acc   = '0;
                        groups_seen = '0;
                        phase       = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (b == STATUS_META) begin
                        phase = PH_MTYPE;
                    end else if (b >= STATUS_CH_LO && b <= STATUS_CH_HI) begin
                        status_q = b;
                        phase    = PH_DATA1;
                    end else begin
                        fault = 1'b1;
                    end
                end
                PH_DATA1, PH_DATA2: begin
                    if (phase == PH_DATA1)
                        first_q = b;
                    if (phase == PH_DATA1 && status_q[7:4] != NIBBLE_PROG
                            && status_q[7:4] != NIBBLE_CHPRESS) begin
                        phase = PH_DATA2;
                    end else begin
                        res.result_kind = KIND_CHAN;
                        res.msg_type    = status_q[6:4];
                        res.channel     = status_q[3:0];
                        res.data_first  = first_q;
                        if (phase == PH_DATA2) begin
                            res.data_second = b;
                            res.data_count  = 2'd2;
                        end else begin
                            res.data_count  = 2'd1;
                        end
                        emit  = 1'b1;
                        done  = 1'b1;
                        phase = PH_DELTA;
                    end
                end
                PH_MTYPE: begin
                    mtype_q   = b;
                    remaining = '0;
                    len_bytes = '0;
                    phase     = PH_MLEN;
                end
                PH_MLEN: begin
                    remaining = {remaining[MLEN_W-8:0], b[6:0]};
                    len_bytes = len_bytes + 3'd1;
                    if (b[7]) begin
                        if (len_bytes >= LEN_BYTES_MAX)
                            fault = 1'b1;
                    end else begin
                        res.result_kind = KIND_META_HDR;
                        res.meta_type   = mtype_q;
                        res.meta_length = remaining;
                        emit            = 1'b1;
                        if (remaining == '0) begin
                            done        = 1'b1;
                            close_after = (mtype_q == META_END_TRACK);
                            phase       = PH_DELTA;
                        end else begin
                            phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    remaining        = remaining - 1'b1;
                    res.result_kind  = KIND_META_BYTE;
                    res.meta_type    = mtype_q;
                    res.payload_byte = b;
                    res.payload_last = (remaining == '0);
                    emit             = 1'b1;
                    if (remaining == '0) begin
                        done        = 1'b1;
                        close_after = (mtype_q == META_END_TRACK);
                        phase       = PH_DELTA;
                    end
                end
                default: begin
                    phase = PH_DELTA;
                    fault = 1'b1;
                end
            endcase
            // an error replaces whatever else the byte would give
            if (fault || (last && !done)) begin
                res             = '0;
                res.result_kind = KIND_ERR;
                emit            = 1'b1;
                halted          = 1'b1;
            end
            res.timestamp = run_time;
            if (last)
                start_track();
            else if (close_after)
                halted = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result seen;
        bit      emit;
        if (!i_rst_n) begin
            start_track();
            status_q = '0;
            first_q  = '0;
            mtype_q  = '0;
            expected_results.delete();
            backlog <= 0;
        end else begin
            // compare before predicting: a result never belongs to a byte of the same edge
            if (i_m_tvalid && i_m_tready) begin
                seen.result_kind  = t_kind'(i_m_tuser);
                seen.timestamp    = i_m_tdata[31:0];
                seen.msg_type     = i_m_tdata[34:32];
                seen.channel      = i_m_tdata[38:35];
                seen.data_first   = i_m_tdata[46:39];
                seen.data_second  = i_m_tdata[54:47];
                seen.data_count   = i_m_tdata[56:55];
                seen.meta_type    = i_m_tdata[64:57];
                seen.meta_length  = i_m_tdata[92:65];
                seen.payload_byte = i_m_tdata[100:93];
                seen.payload_last = i_m_tlast;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, kind", '0, i_m_tuser);
                end else begin
                    want = expected_results.pop_front();
                    if (seen.result_kind !== want.result_kind)
                        report_mismatch("result_kind", want.result_kind, seen.result_kind);
                    if (seen.timestamp !== want.timestamp)
                        report_mismatch("timestamp", want.timestamp, seen.timestamp);
                    if (seen.msg_type !== want.msg_type)
                        report_mismatch("msg_type", want.msg_type, seen.msg_type);
                    if (seen.channel !== want.channel)
                        report_mismatch("channel", want.channel, seen.channel);
                    if (seen.data_first !== want.data_first)
                        report_mismatch("data_first", want.data_first, seen.data_first);
                    if (seen.data_second !== want.data_second)
                        report_mismatch("data_second", want.data_second, seen.data_second);
                    if (seen.data_count !== want.data_count)
                        report_mismatch("data_count", want.data_count, seen.data_count);
                    if (seen.meta_type !== want.meta_type)
                        report_mismatch("meta_type", want.meta_type, seen.meta_type);
                    if (seen.meta_length !== want.meta_length)
                        report_mismatch("meta_length", want.meta_length, seen.meta_length);
                    if (seen.payload_byte !== want.payload_byte)
                        report_mismatch("payload_byte", want.payload_byte, seen.payload_byte);
                    if (seen.payload_last !== want.payload_last)
                        report_mismatch("payload_last", want.payload_last, seen.payload_last);
                end
                if (i_m_tdata[TDATA_W-1:101] !== '0)
                    report_mismatch("tdata padding", '0, i_m_tdata[TDATA_W-1:101]);
            end
            if (i_s_tvalid && i_s_tready) begin
                parse_byte(i_s_tdata, i_s_tlast, emit, want);
                if (emit)
                    expected_results.push_back(want);
            end
            backlog <= expected_results.size();
        end
    end

endmodule

@@ tb/tb_hmp_track_event_parser.sv @@
// Testbench top of the HMP track event parser: clock, reset, byte stream, result sink, verdict.
`timescale 1ns / 1ps

module tb_hmp_track_event_parser;
    import hmpte_pkg::*;

    localparam int         RESET_CYCLES = 10;
    localparam int         RANDOM_BYTES = 1350;
    localparam int         CALM_BYTES   = 150;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         CYCLE_LIMIT  = 400_000;
    localparam logic [7:0] LINK_BIT      = 8'h80;
    localparam logic [7:0] BAD_STATUS_LO = 8'hF0;
    localparam logic [7:0] BAD_STATUS_HI = 8'hFE;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [7:0]         i_s_tdata;
    logic               i_s_tlast;
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [TDATA_W-1:0] o_m_tdata;
    logic [1:0]         o_m_tuser;
    logic               o_m_tlast;
    wire  [31:0]        fail_total;
    wire  [31:0]        backlog;

    t_in_item track_stream[$];
    int       sent_count  = 0;
    int       hold_at     = 0;
    int       calm_from   = 0;
    int       settle_at   = 0;
    int       cycle_count = 0;

    always #5 i_clk = ~i_clk;

    hmp_track_event_parser uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    hmp_track_event_checker event_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_m_tuser     (o_m_tuser),
        .i_m_tlast     (o_m_tlast),
        .o_fail_count  (fail_total),
        .o_outstanding (backlog)
    );

    function automatic void add_byte(input logic [7:0] b);
        t_in_item item;
        item.data_byte  = b;
        item.track_last = 1'b0;
        track_stream.push_back(item);
    endfunction

    function automatic void close_track();
        t_in_item item;
        item = track_stream.pop_back();
        item.track_last = 1'b1;
        track_stream.push_back(item);
    endfunction

    // 7-bit groups, least significant first, link bit on the final group
    function automatic void add_delta(input logic [31:0] ticks, input int groups);
        logic [7:0] piece;
        for (int i = 0; i < groups; i++) begin
            piece = (i < 5) ? 8'((ticks >> (7 * i)) & 32'h7F) : 8'($urandom_range(0, 127));
            add_byte((i == groups - 1) ? (piece | LINK_BIT) : piece);
        end
    endfunction

    // big-endian groups, link bit meaning more to follow
    function automatic void add_length(input logic [27:0] len, input int nbytes);
        logic [7:0] piece;
        for (int i = nbytes - 1; i >= 0; i--) begin
            piece = 8'((len >> (7 * i)) & 28'h7F);
            add_byte((i != 0) ? (piece | LINK_BIT) : piece);
        end
    endfunction

    function automatic void append_message();
        int         pick;
        int         r;
        int         len;
        logic [7:0] status;
        pick = $urandom_range(0, 99);
        r    = $urandom_range(0, 19);
        add_delta($urandom, (r < 10) ? 1 : (r < 15) ? 2 :
                            (r < 18) ? $urandom_range(3, 5) : $urandom_range(6, 7));
        if (pick < 60) begin
            status = 8'($urandom_range(STATUS_CH_LO, STATUS_CH_HI));
            add_byte(status);
            add_byte(8'($urandom));
            if (status[7:4] != NIBBLE_PROG && status[7:4] != NIBBLE_CHPRESS)
                add_byte(8'($urandom));
        end else if (pick < 94) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            add_byte(STATUS_META);
            add_byte(($urandom_range(0, 11) == 0) ? META_END_TRACK : 8'($urandom));
            add_length(len, ($urandom_range(0, 4) == 0) ? $urandom_range(2, 4) : 1);
            repeat (len) add_byte(8'($urandom));
        end else if (pick < 97) begin
            // status neither channel nor meta
            add_byte(($urandom_range(0, 1) == 1) ?
                     8'($urandom_range(BAD_STATUS_LO, BAD_STATUS_HI)) :
                     8'($urandom_range(0, STATUS_CH_LO - 1)));
        end else begin
            // length running past its fourth byte
            add_byte(STATUS_META);
            add_byte(8'($urandom));
            add_length(28'($urandom), 5);
        end
    endfunction

    function automatic void append_track();
        int mode;
        int mark;
        mode = $urandom_range(0, 19);
        mark = track_stream.size();
        if (mode == 0) begin
            repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 10)) begin
                mark = track_stream.size();
                append_message();
            end
            if (mode <= 3) begin
                // stop the track inside its last event
                repeat ($urandom_range(1, track_stream.size() - mark - 1))
                    void'(track_stream.pop_back());
            end else if (mode <= 6) begin
                add_delta($urandom, 1);
                add_byte(STATUS_META);
                add_byte(META_END_TRACK);
                add_length(0, 1);
                repeat ($urandom_range(0, 4)) add_byte(8'($urandom));
            end
        end
        close_track();
    endfunction

    function automatic void build_stimulus();
        // channel events at the extremes of status, data and delta
        add_delta(0, 1);
        add_byte(STATUS_CH_LO);
        add_byte(8'h00);
        add_byte(8'hFF);
        repeat (6) add_byte(8'h7F);
        add_byte(8'hFF);
        add_byte(STATUS_CH_HI);
        add_byte(8'hFF);
        add_byte(8'h80);
        add_delta(1, 1);
        add_byte({NIBBLE_PROG, 4'hF});
        add_byte(8'h80);
        // end of track with empty payload, then bytes that must be ignored
        add_delta(0, 1);
        add_byte(STATUS_META);
        add_byte(META_END_TRACK);
        add_length(0, 1);
        add_byte(8'h55);
        add_byte(8'hAA);
        close_track();
        // bad status
        add_delta(0, 1);
        add_byte(BAD_STATUS_HI);
        add_byte(8'h00);
        close_track();
        // length too long
        add_delta(0, 1);
        add_byte(STATUS_META);
        add_byte(8'h01);
        add_length(1, 5);
        close_track();
        // largest length, then the track ends inside the payload
        add_delta(2, 1);
        add_byte(STATUS_META);
        add_byte(8'h7F);
        add_length(28'hFFF_FFFF, 4);
        add_byte(8'h12);
        add_byte(8'h34);
        close_track();
        // track ends right after a status byte
        add_delta(0, 1);
        add_byte({NIBBLE_CHPRESS, 4'h3});
        close_track();
        settle_at = track_stream.size();
        while (track_stream.size() < settle_at + RANDOM_BYTES)
            append_track();
        hold_at   = settle_at + 300;
        calm_from = track_stream.size() - CALM_BYTES;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result sink: random stalls, one long hold-off, no stalls near the end
    initial begin : sink
        bit held_once;
        held_once  = 1'b0;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!held_once && sent_count >= hold_at) begin
                held_once = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (sent_count < calm_from && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat (($urandom_range(0, 7) == 0) ? 50 : $urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    initial begin : source
        int gap_odds;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tlast  = 1'b0;
        gap_odds   = 0;
        build_stimulus();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < track_stream.size(); k++) begin
            if (k % 64 == 0)
                gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
            if (k == settle_at || k == settle_at + 700) begin
                // hold back until every result so far has left
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (backlog != 0) @(posedge i_clk);
            end else if (k < calm_from && gap_odds != 0
                         && $urandom_range(1, gap_odds) == 1) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= track_stream[k].data_byte;
            i_s_tlast  <= track_stream[k].track_last;
            @(posedge i_clk);
            while (!o_s_tready) @(posedge i_clk);
            sent_count = k + 1;
        end
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (backlog != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_total == 0 && backlog == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/hmpte_pkg.sv
sv/hmpte_in_stage.sv
sv/hmpte_core.sv
sv/hmpte_out_stage.sv
sv/hmp_track_event_parser.sv
tb/hmp_track_event_checker.sv
tb/tb_hmp_track_event_parser.sv
